// ===== hw/rtl/tfpv_pkg.sv =====
// ============================================================================
// Tunnel frame parser package
// Shared constants and types for the tunnel frame parser and validator.
// ============================================================================
package tfpv_pkg;

    // Header and trailer constants
    localparam logic [7:0] MAGIC_BYTE0   = 8'h14;
    localparam logic [7:0] MAGIC_BYTE1   = 8'h1D;
    localparam logic [7:0] KIND_RSVD_MSK = 8'hFE;
    localparam logic [7:0] CODE_RSVD_MSK = 8'hF0;
    localparam logic [7:0] FIXED_ONE     = 8'h01;
    localparam logic [7:0] FIXED_ZERO    = 8'h00;

    // Byte positions within the frame
    localparam int unsigned POS_W       = 9;
    localparam int unsigned SIZE_W      = POS_W + 1;
    localparam logic [POS_W-1:0] POS_MAGIC0 = 9'd0;
    localparam logic [POS_W-1:0] POS_MAGIC1 = 9'd1;
    localparam logic [POS_W-1:0] POS_KIND   = 9'd2;
    localparam logic [POS_W-1:0] POS_CODE   = 9'd3;
    localparam logic [POS_W-1:0] POS_FIXED1 = 9'd5;
    localparam logic [POS_W-1:0] POS_HDR_END = 9'd11;
    localparam logic [POS_W-1:0] POS_LENGTH = 9'd12;
    localparam logic [POS_W-1:0] POS_DATA   = 9'd13;
    localparam logic [POS_W-1:0] POS_MAX    = 9'd511;
    localparam logic [SIZE_W-1:0] MIN_FRAME = 10'd17;

    // Final frame status codes
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_MAGIC = 2'd1,
        STATUS_CORRUPT   = 2'd2,
        STATUS_UNUSED    = 2'd3
    } frame_status_t;

endpackage

// ===== hw/rtl/tunnel_frame_parser_validator_top.sv =====
// ============================================================================
// Tunnel frame parser and validator
// Checks header, length and trailer of a byte stream frame, forwards payload
// bytes as tentative data and reports a final status on the last byte.
// ============================================================================
//
//  Channel | Direction | tdata                         | tlast      | tuser
//  --------+-----------+-------------------------------+------------+------
//  s_      | in        | [7:0] frame_byte              | is_last    | -
//  m_      | out       | [0] payload_valid,            | frame_done | -
//          |           | [8:1] payload_byte,           |            |
//          |           | [10:9] frame_status,          |            |
//          |           | [11] frame_kind,              |            |
//          |           | [15:12] control_code          |            |
//
//  Each request is processed when taken; one byte is accepted per cycle unless the output stalls.
//  A result appears on the master side in the cycle after its byte is taken,
//  held in the output register, and bytes that give no result are absorbed.
//  The single output register sets the rate: a new byte is taken whenever
//  that register is empty or its content is taken in the same cycle.
//  Synchronous active-low reset clears the frame state and the output valid.
//
module tunnel_frame_parser_validator_top
    import tfpv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] frame_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] payload_valid, [8:1] payload_byte,
                                   // [10:9] frame_status, [11] frame_kind,
                                   // [15:12] control_code
    output logic        m_tlast
);

    // Frame state
    logic [POS_W-1:0] byte_position_reg, byte_position_next;
    logic             magic_bad_reg, magic_bad_next;
    logic             header_bad_reg, header_bad_next;
    logic [7:0]       payload_length_reg, payload_length_next;
    logic             kind_bit_reg, kind_bit_next;
    logic [3:0]       control_nibble_reg, control_nibble_next;
    logic [7:0]       recent_bytes_reg [0:4];
    logic [7:0]       recent_bytes_next [0:4];

    // Output register
    logic             out_valid_reg;
    logic [15:0]      out_data_reg, out_data_next;
    logic             out_last_reg;

    logic             accept;
    logic             pay;
    logic             emit;
    logic [7:0]       b;
    logic [SIZE_W-1:0] frame_size;
    logic [SIZE_W-1:0] want_size;
    logic             overrun;
    logic             trailer_bad;
    logic             bad;
    frame_status_t    status;
    logic             kind_out;
    logic [3:0]       code_out;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign b        = s_tdata;

    // Field checks by position and payload detection
    always_comb begin
        magic_bad_next      = magic_bad_reg;
        header_bad_next     = header_bad_reg;
        payload_length_next = payload_length_reg;
        kind_bit_next       = kind_bit_reg;
        control_nibble_next = control_nibble_reg;
        pay                 = 1'b0;
        priority if (byte_position_reg == POS_MAGIC0) begin
            if (b != MAGIC_BYTE0) magic_bad_next = 1'b1;
        end else if (byte_position_reg == POS_MAGIC1) begin
            if (b != MAGIC_BYTE1) magic_bad_next = 1'b1;
        end else if (byte_position_reg == POS_KIND) begin
            if ((b & KIND_RSVD_MSK) != FIXED_ZERO) header_bad_next = 1'b1;
            kind_bit_next = b[0];
        end else if (byte_position_reg == POS_CODE) begin
            if ((b & CODE_RSVD_MSK) != FIXED_ZERO) header_bad_next = 1'b1;
            control_nibble_next = b[3:0];
        end else if (byte_position_reg <= POS_HDR_END) begin
            if (b != ((byte_position_reg == POS_FIXED1) ? FIXED_ONE : FIXED_ZERO))
                header_bad_next = 1'b1;
        end else if (byte_position_reg == POS_LENGTH) begin
            payload_length_next = b;
        end else begin
            pay = ({1'b0, byte_position_reg} <
                   ({1'b0, POS_DATA} + {2'b00, payload_length_reg}));
        end
    end

    // Position counter saturates at its top value
    always_comb begin
        byte_position_next = byte_position_reg;
        if (byte_position_reg != POS_MAX)
            byte_position_next = byte_position_reg + 9'd1;
    end

    // Final status for the last byte
    always_comb begin
        overrun     = (byte_position_reg == POS_MAX);
        frame_size  = {1'b0, byte_position_reg} + 10'd1;
        want_size   = MIN_FRAME + {2'b00, payload_length_next}
                    + {9'd0, (payload_length_next != 8'd0)};
        trailer_bad = (recent_bytes_reg[1] != FIXED_ZERO) ||
                      (recent_bytes_reg[2] != FIXED_ZERO) ||
                      (recent_bytes_reg[3] != FIXED_ONE)  ||
                      (recent_bytes_reg[4] != FIXED_ZERO) ||
                      (b != FIXED_ONE);
        bad = overrun || header_bad_next || trailer_bad ||
              (frame_size != want_size) ||
              (!kind_bit_next && (control_nibble_next != 4'd0));
        priority if (!overrun && (frame_size < MIN_FRAME)) begin
            status = STATUS_CORRUPT;
        end else if (magic_bad_next) begin
            status = STATUS_BAD_MAGIC;
        end else if (bad) begin
            status = STATUS_CORRUPT;
        end else begin
            status = STATUS_OK;
        end
        if (!s_tlast) status = STATUS_OK;
        kind_out = (s_tlast && status == STATUS_OK) ? kind_bit_next : 1'b0;
        code_out = (s_tlast && status == STATUS_OK) ? control_nibble_next : 4'd0;
        emit     = pay || s_tlast;
        out_data_next = {code_out, kind_out, status, (pay ? b : 8'd0), pay};
    end

    // Trailer window shifts in every accepted byte
    always_comb begin
        for (int i = 0; i < 4; i++) recent_bytes_next[i] = recent_bytes_reg[i + 1];
        recent_bytes_next[4] = b;
    end

    // Frame state registers, cleared after each last byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_position_reg  <= '0;
            magic_bad_reg      <= 1'b0;
            header_bad_reg     <= 1'b0;
            payload_length_reg <= '0;
            kind_bit_reg       <= 1'b0;
            control_nibble_reg <= '0;
            for (int i = 0; i < 5; i++) recent_bytes_reg[i] <= '0;
        end else if (accept) begin
            if (s_tlast) begin
                byte_position_reg  <= '0;
                magic_bad_reg      <= 1'b0;
                header_bad_reg     <= 1'b0;
                payload_length_reg <= '0;
                kind_bit_reg       <= 1'b0;
                control_nibble_reg <= '0;
                for (int i = 0; i < 5; i++) recent_bytes_reg[i] <= '0;
            end else begin
                byte_position_reg  <= byte_position_next;
                magic_bad_reg      <= magic_bad_next;
                header_bad_reg     <= header_bad_next;
                payload_length_reg <= payload_length_next;
                kind_bit_reg       <= kind_bit_next;
                control_nibble_reg <= control_nibble_next;
                for (int i = 0; i < 5; i++) recent_bytes_reg[i] <= recent_bytes_next[i];
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_tready) begin
            out_valid_reg <= accept && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            out_data_reg <= out_data_next;
            out_last_reg <= s_tlast;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // A result that is not the last one must carry a payload byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> m_tdata[0])
        else $error("non-final result without payload");

    // Status is never the unused code.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[10:9] != STATUS_UNUSED))
        else $error("invalid frame status");

    // A rejected frame reports no kind or control code.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[10:9] != STATUS_OK) |-> (m_tdata[15:11] == 5'd0))
        else $error("kind or code leaked on a rejected frame");

    // After a last byte the position counter restarts.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast) |=> (byte_position_reg == '0))
        else $error("position not cleared after last byte");

    // Status only appears on the last result of a frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[15:9] == 7'd0))
        else $error("status fields set on a payload-only result");

endmodule

// ===== dv/tb.sv =====
// ============================================================================
// Tunnel frame parser testbench
// Streams whole frames, both well-formed and damaged, into the parser. A
// byte-level predictor tracks the header, length and trailer checks and
// builds the expected payload and status results. The monitor compares
// every result with the oldest prediction. The sender idles in bursts and
// the receiver stalls in changing patterns.
// ============================================================================
module tb
    import tfpv_pkg::*;
();

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          RANDOM_BYTES = 600;
    localparam int          PRINT_CAP    = 40;
    localparam logic [39:0] TRAILER      = 40'h00_00_01_00_01;

    // Ways in which a generated frame is damaged
    typedef enum int {
        FAULT_NONE,
        FAULT_MAGIC,
        FAULT_KIND_RSVD,
        FAULT_CODE_RSVD,
        FAULT_FIXED,
        FAULT_LENGTH,
        FAULT_TRAILER,
        FAULT_TRUNCATE,
        FAULT_NOISE
    } fault_t;

    // One pending request: a frame byte, its last flag and a drain hold-off
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       drain;
    } frame_req_t;

    // One expected result, in the order of the m_tdata fields
    typedef struct packed {
        logic       pay_valid;
        logic [7:0] pay_byte;
        logic       done;
        logic [1:0] status;
        logic       kind;
        logic [3:0] code;
    } parse_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] frame_byte
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [0] payload_valid, [8:1] payload_byte,
                                     // [10:9] frame_status, [11] frame_kind,
                                     // [15:12] control_code
    logic        m_tlast;

    frame_req_t    frame_bytes_q[$];
    parse_result_t expected_results[$];

    int   error_count    = 0;
    int   result_count   = 0;
    int   accepted_count = 0;
    int   queued_count   = 0;
    int   cycle_count    = 0;
    logic s_taken        = 1'b0;

    // Predictor copy of the frame state
    logic [8:0]       frame_pos;
    logic             magic_err;
    logic             header_err;
    logic [7:0]       length_byte;
    logic             kind_seen;
    logic [3:0]       code_seen;
    logic [4:0][7:0]  tail_bytes;   // [0] is the most recent byte

    // Sender and receiver idling state
    int   burst_left  = 1;
    int   gap_left    = 0;
    int   ready_mode  = 0;
    int   ready_hold  = 0;
    logic [2:0] ready_phase = 3'd0;

    tunnel_frame_parser_validator_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Clock generation
    initial begin
        forever #10 aclk = ~aclk;
    end

    // Mismatch reporting: one line per failure, printing capped
    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < PRINT_CAP) begin
            $display("tb: error on %s at result %0d: got 0x%0h, expected 0x%0h",
                     what, result_count, got, want);
        end
        error_count++;
    endtask

    task automatic clear_frame_state();
        frame_pos   = '0;
        magic_err   = 1'b0;
        header_err  = 1'b0;
        length_byte = '0;
        kind_seen   = 1'b0;
        code_seen   = '0;
        tail_bytes  = '0;
    endtask

    // Frame predictor: consumes one accepted byte and queues its result, if any
    task automatic parse_frame_byte(input logic [7:0] b, input logic last);
        int            idx;
        int            frame_size;
        int            want_size;
        logic          pay;
        logic          bad;
        frame_status_t st;
        parse_result_t r;
        idx = int'(frame_pos);
        pay = 1'b0;
        st  = STATUS_OK;
        r   = '0;

        // Field checks by byte position
        if (idx == int'(POS_MAGIC0)) begin
            if (b != MAGIC_BYTE0) magic_err = 1'b1;
        end else if (idx == int'(POS_MAGIC1)) begin
            if (b != MAGIC_BYTE1) magic_err = 1'b1;
        end else if (idx == int'(POS_KIND)) begin
            if ((b & KIND_RSVD_MSK) != 8'h00) header_err = 1'b1;
            kind_seen = b[0];
        end else if (idx == int'(POS_CODE)) begin
            if ((b & CODE_RSVD_MSK) != 8'h00) header_err = 1'b1;
            code_seen = b[3:0];
        end else if (idx <= int'(POS_HDR_END)) begin
            if (b != ((idx == int'(POS_FIXED1)) ? FIXED_ONE : FIXED_ZERO)) begin
                header_err = 1'b1;
            end
        end else if (idx == int'(POS_LENGTH)) begin
            length_byte = b;
        end else if (idx < int'(POS_DATA) + int'(length_byte)) begin
            pay = 1'b1;
        end

        tail_bytes = {tail_bytes[3:0], b};
        if (frame_pos != POS_MAX) frame_pos = frame_pos + 9'd1;

        if (!pay && !last) return;

        r.pay_valid = pay;
        r.pay_byte  = pay ? b : 8'h00;
        r.done      = last;

        // Final status: short frame first, then magic, then everything else
        if (last) begin
            frame_size = idx + 1;
            want_size  = int'(MIN_FRAME) + int'(length_byte) + ((length_byte != 0) ? 1 : 0);
            if (idx != int'(POS_MAX) && frame_size < int'(MIN_FRAME)) begin
                st = STATUS_CORRUPT;
            end else if (magic_err) begin
                st = STATUS_BAD_MAGIC;
            end else begin
                bad = (idx == int'(POS_MAX)) || header_err;
                if (tail_bytes != TRAILER) bad = 1'b1;
                if (frame_size != want_size) bad = 1'b1;
                if (!kind_seen && code_seen != 4'h0) bad = 1'b1;
                st = bad ? STATUS_CORRUPT : STATUS_OK;
            end
            if (st == STATUS_OK) begin
                r.kind = kind_seen;
                r.code = code_seen;
            end
            r.status = st;
            clear_frame_state();
        end
        expected_results.insert(expected_results.size(), r);
    endtask

    // Compare one accepted result with the oldest prediction
    task automatic check_result();
        parse_result_t want;
        if (expected_results.size() == 0) begin
            report_mismatch("unexpected result", int'({m_tlast, m_tdata}), 0);
        end else begin
            want = expected_results.pop_front();
            if (m_tdata[0] !== want.pay_valid)
                report_mismatch("payload_valid", int'(m_tdata[0]), int'(want.pay_valid));
            if (m_tdata[8:1] !== want.pay_byte)
                report_mismatch("payload_byte", int'(m_tdata[8:1]), int'(want.pay_byte));
            if (m_tlast !== want.done)
                report_mismatch("frame_done", int'(m_tlast), int'(want.done));
            if (m_tdata[10:9] !== want.status)
                report_mismatch("frame_status", int'(m_tdata[10:9]), int'(want.status));
            if (m_tdata[11] !== want.kind)
                report_mismatch("frame_kind", int'(m_tdata[11]), int'(want.kind));
            if (m_tdata[15:12] !== want.code)
                report_mismatch("control_code", int'(m_tdata[15:12]), int'(want.code));
        end
        result_count++;
    endtask

    // Build one frame, damage it as asked and queue its bytes as requests
    task automatic queue_frame(input int len, input logic kind, input logic [3:0] code,
                               input fault_t f1, input fault_t f2, input int pad,
                               input int cut_in, input bit drain);
        logic [7:0] fb[$];
        fault_t     f;
        frame_req_t req;
        int         i;
        int         k;
        int         cut;
        cut = cut_in;
        fb  = {};
        fb.insert(fb.size(), MAGIC_BYTE0);
        fb.insert(fb.size(), MAGIC_BYTE1);
        fb.insert(fb.size(), {7'd0, kind});
        fb.insert(fb.size(), {4'd0, code});
        for (i = 4; i <= int'(POS_HDR_END); i++) begin
            fb.insert(fb.size(), (i == int'(POS_FIXED1)) ? FIXED_ONE : FIXED_ZERO);
        end
        fb.insert(fb.size(), 8'(len));
        repeat (len + pad) fb.insert(fb.size(), 8'($urandom));
        // With a zero length and no padding the length byte doubles as the first trailer byte
        for (i = (len == 0 && pad == 0) ? 1 : 0; i < 5; i++) begin
            fb.insert(fb.size(), TRAILER[8*(4-i) +: 8]);
        end

        for (k = 0; k < 2; k++) begin
            f = (k == 0) ? f1 : f2;
            case (f)
                FAULT_MAGIC: begin
                    i = $urandom_range(0, 1);
                    fb[i] = fb[i] ^ 8'($urandom_range(1, 255));
                end
                FAULT_KIND_RSVD: begin
                    fb[2] = fb[2] | 8'(1 << $urandom_range(1, 7));
                end
                FAULT_CODE_RSVD: begin
                    fb[3] = fb[3] | 8'(1 << $urandom_range(4, 7));
                end
                FAULT_FIXED: begin
                    i = $urandom_range(4, 11);
                    fb[i] = fb[i] ^ 8'(1 << $urandom_range(0, 7));
                end
                FAULT_LENGTH: begin
                    if (len != 0 && $urandom_range(0, 1) == 1) fb.delete(13);
                    else fb.insert(13, 8'($urandom));
                end
                FAULT_TRAILER: begin
                    i = fb.size() - 1 - $urandom_range(0, 4);
                    fb[i] = fb[i] ^ 8'(1 << $urandom_range(0, 7));
                end
                FAULT_TRUNCATE: begin
                    if (cut == 0) cut = $urandom_range(1, 16);
                end
                FAULT_NOISE: begin
                    fb = {};
                    repeat ($urandom_range(1, 40)) fb.insert(fb.size(), 8'($urandom));
                end
                default: ;
            endcase
        end
        if (cut > 0 && cut < fb.size()) fb = fb[0:cut-1];

        for (i = 0; i < fb.size(); i++) begin
            req.data  = fb[i];
            req.last  = (i == fb.size() - 1);
            req.drain = drain && (i == 0);
            frame_bytes_q.insert(frame_bytes_q.size(), req);
        end
    endtask

    // Stimulus, reset and end of run
    initial begin : stimulus
        int     stim_bytes;
        int     frame_no;
        int     before_size;
        int     len;
        int     pad;
        int     pick;
        bit     drain;
        logic   kind;
        logic [3:0] code;
        fault_t f1;
        fault_t f2;

        // Directed frames: smallest valid control frame with the top code,
        // a one-byte frame, and a short frame ending inside its payload
        queue_frame(0, 1'b1, 4'hF, FAULT_NONE, FAULT_NONE, 0, 0, 1'b0);
        queue_frame(0, 1'b0, 4'h0, FAULT_MAGIC, FAULT_NONE, 0, 1, 1'b0);
        queue_frame(4, 1'b0, 4'h0, FAULT_NONE, FAULT_NONE, 0, 14, 1'b0);

        // Random frames, mostly well-formed with random content
        stim_bytes = 0;
        frame_no   = 0;
        while (stim_bytes < RANDOM_BYTES) begin
            len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            kind   = 1'($urandom_range(0, 1));
            code   = (kind || $urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15)) : 4'h0;
            pad    = 0;
            f1     = FAULT_NONE;
            f2     = FAULT_NONE;
            pick   = $urandom_range(0, 99);
            if (pick < 8) begin
                f1 = FAULT_NOISE;
            end else if (pick < 40) begin
                f1 = fault_t'($urandom_range(int'(FAULT_MAGIC), int'(FAULT_TRUNCATE)));
                if ($urandom_range(0, 4) == 0) begin
                    f2 = fault_t'($urandom_range(int'(FAULT_MAGIC), int'(FAULT_TRUNCATE)));
                end
            end

            // One large frame: longest payload, reaching the counter's top value
            if (frame_no == 3) begin
                len = 255; kind = 1'b1; pad = 512 - 18 - len;
                f1 = FAULT_NONE; f2 = FAULT_NONE;
            end

            drain       = (frame_no == 5) || ($urandom_range(0, 19) == 0);
            before_size = frame_bytes_q.size();
            queue_frame(len, kind, code, f1, f2, pad, 0, drain);
            stim_bytes += frame_bytes_q.size() - before_size;
            frame_no++;
        end
        queued_count = frame_bytes_q.size();

        // Reset held low from the start, released at a falling edge
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Wait until every byte is taken and every result has come
        do @(negedge aclk);
        while (accepted_count != queued_count || expected_results.size() != 0);
        repeat (10) @(negedge aclk);

        if (error_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    // Sender: bursts of requests with random gaps, holding a request until taken
    always @(negedge aclk) begin : sender
        frame_req_t nxt;
        logic       v;
        logic [7:0] d;
        logic       l;
        v = s_tvalid;
        d = s_tdata;
        l = s_tlast;
        if (!aresetn) begin
            v = 1'b0;
        end else if (!(s_tvalid && !s_taken)) begin
            v = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (frame_bytes_q.size() != 0 &&
                         !(frame_bytes_q[0].drain && expected_results.size() != 0)) begin
                nxt = frame_bytes_q.pop_front();
                v = 1'b1;
                d = nxt.data;
                l = nxt.last;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                             : $urandom_range(1, 8);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end
            end
        end
        s_tvalid <= v;
        s_tdata  <= d;
        s_tlast  <= l;
    end

    // Receiver: ready pattern that switches between modes from time to time
    always @(negedge aclk) begin
        if (ready_hold == 0) begin
            ready_mode <= $urandom_range(0, 3);
            ready_hold <= $urandom_range(20, 200);
        end else begin
            ready_hold <= ready_hold - 1;
        end
        case (ready_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 7) == 0);
            default: m_tready <= ready_phase[2];
        endcase
        ready_phase <= ready_phase + 3'd1;
    end

    // Monitor: check results, then predict from accepted requests
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_taken <= 1'b0;
            clear_frame_state();
        end else begin
            s_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) check_result();
            if (s_tvalid && s_tready) begin
                parse_frame_byte(s_tdata, s_tlast);
                accepted_count++;
            end
        end
    end

    // Watchdog on the total run length
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
hw/rtl/tfpv_pkg.sv
hw/rtl/tunnel_frame_parser_validator_top.sv
dv/tb.sv
